[src/fia_pkg.sv]
// ----------------------------------------------------------------------------
// fia_pkg
// Shared types for the FIFO index allocator: transaction payloads, the
// controller state encoding and the controller/datapath command and status.
// ----------------------------------------------------------------------------
`default_nettype none

package fia_pkg;

   localparam int unsigned FIELD_W = 11;

   // Request operation codes
   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   typedef struct packed {
      logic               operation;
      logic [FIELD_W-1:0] index;
   } req_type;

   typedef struct packed {
      logic [FIELD_W-1:0] alloc_index;
      logic               done_res;
      logic [FIELD_W-1:0] in_use_count;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_UPDATE
   } state_type;

   typedef struct packed {
      logic clear_step;
      logic accept;
      logic read;
      logic update;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
   } status_type;

endpackage

`default_nettype wire

[src/fifo_index_allocator.sv]
// A request accepted in idle steps through the read and update states;
// the response is registered and strobed after the update.
// A new request is taken only once the block is idle again; each
// transaction needs the registered RAM read of the free queue and in-use
// bitmap followed by the update write. Reset: synchronous; afterwards the
// bitmap is swept clear, and busy stays high until the sweep ends.
// ----------------------------------------------------------------------------
// fifo_index_allocator
// Hands out identifiers 1..POOL_SIZE from a FIFO free list with an in-use
// bitmap guarding frees.
// ----------------------------------------------------------------------------
`default_nettype none

module fifo_index_allocator #(
   parameter int unsigned POOL_SIZE = 1024
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output      logic             busy,
   input  wire fia_pkg::req_type req,
   output      logic             rsp_strobe,
   output      fia_pkg::rsp_type rsp
);

   import fia_pkg::*;

   cmd_type    cmd;
   status_type status;

   fia_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   fia_datapath #(.POOL_SIZE(POOL_SIZE)) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req        (req),
      .rsp_strobe (rsp_strobe),
      .rsp        (rsp)
   );

endmodule

`default_nettype wire

[src/fia_ram.sv]
// ----------------------------------------------------------------------------
// fia_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module fia_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  wire logic                                         clock,
   input  wire logic                                         wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]   wr_addr,
   input  wire logic [WIDTH-1:0]                             wr_data,
   input  wire logic                                         rd_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]   rd_addr,
   output      logic [WIDTH-1:0]                             rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

[src/fia_ctrl.sv]
// ----------------------------------------------------------------------------
// fia_ctrl
// Controller: sequences the bitmap clearing sweep and the read / update
// steps of each transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module fia_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output      logic                busy,
   input  wire fia_pkg::status_type status,
   output      fia_pkg::cmd_type    cmd
);

   import fia_pkg::*;

   state_type state_ff;
   state_type state_in;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               state_in = ST_READ;
            end
         end
         ST_READ:   state_in = ST_UPDATE;
         ST_UPDATE: state_in = ST_IDLE;
         default:   state_in = ST_CLEAR;
      endcase
   end

   // Outputs
   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      unique case (state_ff)
         ST_CLEAR:  cmd.clear_step = 1'b1;
         ST_IDLE: begin
            busy       = 1'b0;
            cmd.accept = start;
         end
         ST_READ:   cmd.read   = 1'b1;
         ST_UPDATE: cmd.update = 1'b1;
         default:   busy = 1'b1;
      endcase
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

[src/fia_datapath.sv]
// ----------------------------------------------------------------------------
// fia_datapath
// Datapath: free queue and in-use bitmap RAMs, queue pointers, free count
// and the response register.
// ----------------------------------------------------------------------------
`default_nettype none

module fia_datapath #(
   parameter int unsigned POOL_SIZE = 1024
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire fia_pkg::cmd_type    cmd,
   output      fia_pkg::status_type status,
   input  wire fia_pkg::req_type    req,
   output      logic                rsp_strobe,
   output      fia_pkg::rsp_type    rsp
);

   import fia_pkg::*;

   localparam int unsigned ID_W = $clog2(POOL_SIZE + 1);
   localparam int unsigned QA_W = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
   localparam logic [ID_W-1:0] POOL_ID = ID_W'(POOL_SIZE);
   localparam logic [QA_W-1:0] LAST_SLOT = QA_W'(POOL_SIZE - 1);

   // Registers
   logic              op_ff, op_in;
   logic [FIELD_W-1:0] id_ff, id_in;
   logic [QA_W-1:0]   head_ff, head_in;
   logic [QA_W-1:0]   tail_ff, tail_in;
   logic              wrapped_ff, wrapped_in;
   logic [ID_W-1:0]   count_ff, count_in;
   logic [ID_W-1:0]   clr_ff, clr_in;
   rsp_type           rsp_ff, rsp_in;
   logic              strobe_ff, strobe_in;

   // RAM ports
   logic              q_wr_en;
   logic [ID_W-1:0]   q_rd_data;
   logic              m_wr_en;
   logic [ID_W-1:0]   m_wr_addr;
   logic              m_wr_data;
   logic              m_rd_en;
   logic              m_rd_data;

   // Decode
   logic              q_written;
   logic [ID_W-1:0]   grant_id;
   logic              id_in_range;
   logic              alloc_ok;
   logic              free_ok;

   fia_ram #(.WIDTH(ID_W), .DEPTH(POOL_SIZE)) u_queue (
      .clock   (clock),
      .wr_en   (q_wr_en),
      .wr_addr (tail_ff),
      .wr_data (ID_W'(id_ff)),
      .rd_en   (cmd.read),
      .rd_addr (head_ff),
      .rd_data (q_rd_data)
   );

   fia_ram #(.WIDTH(1), .DEPTH(POOL_SIZE + 1)) u_in_use (
      .clock   (clock),
      .wr_en   (m_wr_en),
      .wr_addr (m_wr_addr),
      .wr_data (m_wr_data),
      .rd_en   (m_rd_en),
      .rd_addr (ID_W'(id_ff)),
      .rd_data (m_rd_data)
   );

   // Slots behind the tail hold written data; the rest stand for slot+1
   assign q_written   = wrapped_ff || (head_ff < tail_ff);
   assign grant_id    = q_written ? q_rd_data : (ID_W'(head_ff) + ID_W'(1));
   assign id_in_range = (id_ff != '0) && (32'(id_ff) <= POOL_SIZE);
   assign alloc_ok    = (op_ff == OP_ALLOC) && (count_ff != '0);
   assign free_ok     = (op_ff == OP_FREE) && id_in_range && m_rd_data
                        && (count_ff < POOL_ID);

   assign q_wr_en = cmd.update && free_ok;
   assign m_rd_en = cmd.read && id_in_range;

   // Bitmap write: clearing sweep, mark on allocate, unmark on free
   always_comb begin
      m_wr_en   = 1'b0;
      m_wr_addr = clr_ff;
      m_wr_data = 1'b0;
      if (cmd.clear_step) begin
         m_wr_en = 1'b1;
      end else if (cmd.update && alloc_ok) begin
         m_wr_en   = 1'b1;
         m_wr_addr = grant_id;
         m_wr_data = 1'b1;
      end else if (cmd.update && free_ok) begin
         m_wr_en   = 1'b1;
         m_wr_addr = ID_W'(id_ff);
      end
   end

   assign status.clear_last = (clr_ff == POOL_ID);

   // Next values
   always_comb begin
      op_in      = op_ff;
      id_in      = id_ff;
      head_in    = head_ff;
      tail_in    = tail_ff;
      wrapped_in = wrapped_ff;
      count_in   = count_ff;
      clr_in     = clr_ff;
      rsp_in     = rsp_ff;
      strobe_in  = cmd.update;

      // advance the sweep address
      if (cmd.clear_step) begin
         clr_in = clr_ff + ID_W'(1);
      end

      // capture the transaction
      if (cmd.accept) begin
         op_in = req.operation;
         id_in = req.index;
      end

      // pop the head or push the tail
      if (cmd.update && alloc_ok) begin
         head_in  = (head_ff == LAST_SLOT) ? '0 : head_ff + QA_W'(1);
         count_in = count_ff - ID_W'(1);
      end
      if (cmd.update && free_ok) begin
         if (tail_ff == LAST_SLOT) begin
            tail_in    = '0;
            wrapped_in = 1'b1;
         end else begin
            tail_in = tail_ff + QA_W'(1);
         end
         count_in = count_ff + ID_W'(1);
      end

      // build the response
      if (cmd.update) begin
         rsp_in.alloc_index  = alloc_ok ? FIELD_W'(grant_id) : '0;
         rsp_in.done_res     = alloc_ok || free_ok;
         rsp_in.in_use_count = FIELD_W'(POOL_ID - count_in);
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff    <= '0;
         tail_ff    <= '0;
         wrapped_ff <= 1'b0;
         count_ff   <= POOL_ID;
         clr_ff     <= '0;
         strobe_ff  <= 1'b0;
      end else begin
         head_ff    <= head_in;
         tail_ff    <= tail_in;
         wrapped_ff <= wrapped_in;
         count_ff   <= count_in;
         clr_ff     <= clr_in;
         strobe_ff  <= strobe_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      op_ff  <= op_in;
      id_ff  <= id_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp        = rsp_ff;

endmodule

`default_nettype wire

[src/fia_checker.sv]
// ----------------------------------------------------------------------------
// fia_checker
// Port-level checks on transaction timing and response consistency.
// ----------------------------------------------------------------------------
`default_nettype none

module fia_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             start,
   input wire logic             busy,
   input wire logic             rsp_strobe,
   input wire fia_pkg::rsp_type rsp
);

   import fia_pkg::*;

   // Accepting a transaction makes the block busy
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after accept");

   // Every accepted transaction is answered with a response strobe
   a_rsp_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##3 rsp_strobe)
      else $error("response missing three cycles after accept");

   // Strobe lasts a single cycle
   a_strobe_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("response strobe held longer than one cycle");

   // A granted identifier always comes with done
   a_grant_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp.alloc_index != '0)) |-> rsp.done_res)
      else $error("identifier granted without done");

endmodule

bind fifo_index_allocator fia_checker u_fia_checker (.*);

`default_nettype wire
